@@ rtl/core/cdad_pkg.sv @@
// ============================================================================
// cdad_pkg: calendar date adder shared types
// Date record, step unit result, sequencer states, op codes and month length.
// ============================================================================
package cdad_pkg;

   localparam logic       OP_SET      = 1'b0;
   localparam logic       OP_ADD      = 1'b1;

   localparam logic [3:0]  MONTH_FIRST = 4'd1;
   localparam logic [3:0]  MONTH_LAST  = 4'd12;
   localparam logic [15:0] YEAR_MAX    = 16'hFFFF;

   localparam logic [3:0]  MONTH_FEB   = 4'd2;
   localparam logic [3:0]  MONTH_APR   = 4'd4;
   localparam logic [3:0]  MONTH_JUN   = 4'd6;
   localparam logic [3:0]  MONTH_SEP   = 4'd9;
   localparam logic [3:0]  MONTH_NOV   = 4'd11;

   localparam logic [4:0]  LEN_SHORT   = 5'd30;
   localparam logic [4:0]  LEN_LONG    = 5'd31;
   localparam logic [4:0]  LEN_FEB_LEAP = 5'd29;
   localparam logic [4:0]  LEN_FEB     = 5'd28;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef struct packed {
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
   } date_type;

   typedef struct packed {
      date_type    date;
      logic [15:0] remain;
      logic        done;
   } step_type;

   // Month length; an invalid month has length zero.
   function automatic logic [4:0] month_len(input logic [3:0] m, input logic [15:0] y);
      logic [4:0] len;
      len = 5'd0;
      if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV) begin
         len = LEN_SHORT;
      end else if (m == MONTH_FEB) begin
         len = (y[1:0] == 2'b00) ? LEN_FEB_LEAP : LEN_FEB;
      end else if (m >= MONTH_FIRST && m <= MONTH_LAST) begin
         len = LEN_LONG;
      end
      return len;
   endfunction

endpackage

@@ rtl/core/calendar_date_add_days_top.sv @@
// ============================================================================
// calendar_date_add_days_top: calendar date register with set and add-days
// Holds day, month and year; loads a validated date or walks forward a day
// count one month per cycle, and returns the date after every item.
// ============================================================================
//
//   channel   ports                               handshake
//   --------  ----------------------------------  ----------------------------
//   request   req_op, req_set_day, req_set_month,  taken when start & !busy
//             req_set_year, req_add_count
//   response  rsp_cur_day, rsp_cur_month,          one-cycle rsp_valid strobe
//             rsp_cur_year
//
// Timing: a set item returns its date in the cycle after it is taken and
//   leaves busy low, so another item may follow at once. An add item holds
//   busy while the shared step unit walks one month a cycle over the month
//   boundaries it crosses (up to about 2150 for the largest count); the
//   strobe shows in the first cycle with busy low again.
// Reset: synchronous, clears the date to 0/0/0 and the sequencer to idle.
// Stalls: the receiver cannot stall; every strobe is taken as it is shown.
// ============================================================================
module calendar_date_add_days_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [4:0]  req_set_day,
   input  logic [3:0]  req_set_month,
   input  logic [15:0] req_set_year,
   input  logic [15:0] req_add_count,
   output logic        rsp_valid,
   output logic [4:0]  rsp_cur_day,
   output logic [3:0]  rsp_cur_month,
   output logic [15:0] rsp_cur_year
);

   cdad_pkg::state_type state_ff, state_in;
   cdad_pkg::date_type  date_ff, date_in;
   logic [15:0]         remain_ff, remain_in;
   logic                rsp_valid_ff, rsp_valid_in;

   cdad_pkg::step_type  step;
   logic [4:0]          set_len;
   logic                accept;

   // shared month step unit
   cdad_step_unit u_step (
      .cur_date (date_ff),
      .remain   (remain_ff),
      .step     (step)
   );

   assign accept  = start && (state_ff == cdad_pkg::ST_IDLE);
   assign set_len = cdad_pkg::month_len(req_set_month, req_set_year);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdad_pkg::ST_IDLE;
         date_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         date_ff      <= date_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // count register carries no reset: loaded on every add item
   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
   end

   always_comb begin
      state_in     = state_ff;
      date_in      = date_ff;
      remain_in    = remain_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         cdad_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_op == cdad_pkg::OP_SET) begin
                  // load and validate: a bad month has length zero, which drops the day too
                  date_in.month = (set_len != 5'd0) ? req_set_month : 4'd0;
                  date_in.day   = (req_set_day != 5'd0 && req_set_day <= set_len)
                                  ? req_set_day : 5'd0;
                  date_in.year  = req_set_year;
                  rsp_valid_in  = 1'b1;
               end else begin
                  // hold the count and start walking months
                  remain_in = req_add_count;
                  state_in  = cdad_pkg::ST_WALK;
               end
            end
         end
         cdad_pkg::ST_WALK: begin
            // advance one month per cycle until the count lands
            date_in   = step.date;
            remain_in = step.remain;
            if (step.done) begin
               state_in     = cdad_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = cdad_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff == cdad_pkg::ST_WALK);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_cur_day   = date_ff.day;
   assign rsp_cur_month = date_ff.month;
   assign rsp_cur_year  = date_ff.year;

`ifndef ASSERT_OFF
   a_rsp_date_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (date_ff.month <= cdad_pkg::MONTH_LAST &&
                     date_ff.day <= cdad_pkg::month_len(date_ff.month, date_ff.year)))
      else $error("response date out of calendar range");

   a_add_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == cdad_pkg::OP_ADD) |=> busy)
      else $error("add item did not start the walk");

   a_walk_end_strobe: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("walk ended without a response");

   a_no_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && !step.done) |=> !rsp_valid && date_ff.day == 5'd1)
      else $error("mid-walk step did not land on the first of a month");
`endif

endmodule

@@ rtl/core/cdad_step_unit.sv @@
// ============================================================================
// cdad_step_unit: one month step of the day walk
// Consume the rest of the current month or finish inside it.
// ============================================================================
module cdad_step_unit (
   input  cdad_pkg::date_type cur_date,
   input  logic [15:0]        remain,
   output cdad_pkg::step_type step
);

   logic [4:0]  len;
   logic [17:0] after;
   logic [17:0] after_m1;
   logic [3:0]  next_month;

   always_comb begin
      len        = cdad_pkg::month_len(cur_date.month, cur_date.year);
      after      = {2'b00, remain} - {13'd0, len} + {13'd0, cur_date.day};
      after_m1   = after - 18'd1;
      next_month = (cur_date.month >= cdad_pkg::MONTH_LAST) ? cdad_pkg::MONTH_FIRST
                                                            : cur_date.month + 4'd1;
      step        = '0;
      step.date   = cur_date;
      step.remain = remain;
      if (after == 18'd0) begin
         step.date.day = len;
         step.done     = 1'b1;
      end else if (after[17]) begin
         // finish inside this month
         step.date.day = cur_date.day + remain[4:0];
         step.done     = 1'b1;
      end else begin
         // advance to the 1st of the next month
         step.remain     = after_m1[15:0];
         step.date.day   = 5'd1;
         step.date.month = next_month;
         if (next_month == cdad_pkg::MONTH_FIRST && cur_date.year != cdad_pkg::YEAR_MAX) begin
            step.date.year = cur_date.year + 16'd1;
         end
      end
   end

endmodule

@@ test/calendar_date_add_days_top_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// calendar_date_add_days_top_test: self-checking bench for the date adder
// Feeds date loads and day advances through the start/busy command port,
// predicts every returned date with an independent calendar walk and checks
// each rsp_valid strobe field by field against the oldest prediction.
// ============================================================================
module calendar_date_add_days_top_test;

   // An add of 65535 days walks about 2150 months, one per cycle, so allow a
   // few times that plus the longest sender gap before calling the run hung.
   localparam int WATCHDOG_LIMIT = 10000;
   localparam int RANDOM_ITEMS   = 1230;
   localparam int SETTLE_CYCLES  = 20;

   typedef struct {
      logic        op;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [15:0] year;
      logic [15:0] count;
      bit          drain_first;   // marker: hold the sender until all dates are back
   } date_request_type;

   logic        clock;
   logic        reset         = 1'b1;
   logic        start         = 1'b0;
   logic        busy;
   logic        req_op        = cdad_pkg::OP_SET;
   logic [4:0]  req_set_day   = '0;
   logic [3:0]  req_set_month = '0;
   logic [15:0] req_set_year  = '0;
   logic [15:0] req_add_count = '0;
   logic        rsp_valid;
   logic [4:0]  rsp_cur_day;
   logic [3:0]  rsp_cur_month;
   logic [15:0] rsp_cur_year;

   date_request_type   pending_requests[$];
   cdad_pkg::date_type expected_dates[$];

   // Predicted calendar register, mirrors the block's stored date.
   logic [4:0]  held_day   = '0;
   logic [3:0]  held_month = '0;
   logic [15:0] held_year  = '0;

   logic item_accepted = 1'b0;
   int   burst_left    = 1;
   int   gap_left      = 0;
   int   idle_cycles   = 0;
   int   mismatch_count = 0;
   int   loads_taken    = 0;
   int   advances_taken = 0;
   int   months_walked  = 0;

   calendar_date_add_days_top u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_op        (req_op),
      .req_set_day   (req_set_day),
      .req_set_month (req_set_month),
      .req_set_year  (req_set_year),
      .req_add_count (req_add_count),
      .rsp_valid     (rsp_valid),
      .rsp_cur_day   (rsp_cur_day),
      .rsp_cur_month (rsp_cur_month),
      .rsp_cur_year  (rsp_cur_year)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // Days in month m of year y; anything outside 1..12 counts as an empty month.
   function automatic int days_in_month(input logic [3:0] m, input logic [15:0] y);
      case (m)
         4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
         4'd2:                                       return (y[1:0] == 2'b00) ? 29 : 28;
         default:                                    return 0;
      endcase
   endfunction

   // Apply one item to the predicted register and return the date it leaves.
   function automatic cdad_pkg::date_type next_calendar_date(input date_request_type item);
      cdad_pkg::date_type result;
      int       len;
      int       remain;
      int       left;
      int       after;
      bit       stepping;
      if (item.op == cdad_pkg::OP_SET) begin
         loads_taken++;
         len        = days_in_month(item.month, item.year);
         held_month = (item.month >= cdad_pkg::MONTH_FIRST &&
                       item.month <= cdad_pkg::MONTH_LAST) ? item.month : 4'd0;
         held_day   = (item.day != 5'd0 && int'(item.day) <= len) ? item.day : 5'd0;
         held_year  = item.year;
      end else begin
         advances_taken++;
         remain   = int'(item.count);
         stepping = 1'b1;
         while (stepping) begin
            len   = days_in_month(held_month, held_year);
            left  = len - int'(held_day);
            after = remain - left;
            if (after == 0) begin
               // lands exactly on the last day of this month
               held_day = 5'(len);
               stepping = 1'b0;
            end else if (after < 0) begin
               held_day = 5'(int'(held_day) + remain);
               stepping = 1'b0;
            end else begin
               // cross into the 1st of the next month; the year sticks at its top
               remain = after - 1;
               months_walked++;
               held_month = (held_month >= cdad_pkg::MONTH_LAST) ? cdad_pkg::MONTH_FIRST
                                                                 : held_month + 4'd1;
               if (held_month == cdad_pkg::MONTH_FIRST && held_year != cdad_pkg::YEAR_MAX) begin
                  held_year = held_year + 16'd1;
               end
               held_day = 5'd1;
            end
         end
      end
      result.day   = held_day;
      result.month = held_month;
      result.year  = held_year;
      return result;
   endfunction

   function automatic void add_request(input logic op, input int d, input int m,
                                       input int y, input int c);
      date_request_type r;
      r.op          = op;
      r.day         = 5'(d);
      r.month       = 4'(m);
      r.year        = 16'(y);
      r.count       = 16'(c);
      r.drain_first = 1'b0;
      pending_requests.push_back(r);
   endfunction

   // Sender: change inputs on the falling edge. Items go out in bursts of
   // random length with random gaps; a zero gap gives stretches of back-to-back
   // items. A drain marker holds the sender until every date has come back.
   always @(negedge clock) begin : drive_requests
      logic             next_start;
      date_request_type item;
      next_start = start;
      if (!reset) begin
         // drop start once the block has taken the item it was showing
         if (start && item_accepted) begin
            next_start = 1'b0;
         end
         if (!next_start) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               if (pending_requests[0].drain_first) begin
                  if (expected_dates.size() == 0) begin
                     pending_requests.delete(0);
                  end
               end else begin
                  item = pending_requests.pop_front();
                  req_op        <= item.op;
                  req_set_day   <= item.day;
                  req_set_month <= item.month;
                  req_set_year  <= item.year;
                  req_add_count <= item.count;
                  next_start = 1'b1;
                  burst_left--;
                  if (burst_left <= 0) begin
                     burst_left = $urandom_range(1, 24);
                     gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                  end
               end
            end
         end
      end
      start <= next_start;
   end

   // Receiver: sample on the rising edge. Check the strobe first, then queue
   // the prediction for an item taken at this edge, so the order is fixed.
   always @(posedge clock) begin : check_dates
      cdad_pkg::date_type due;
      date_request_type   taken;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_dates.size() == 0) begin
               $display("%0t: date %0d/%0d/%0d returned with none expected", $time,
                        rsp_cur_day, rsp_cur_month, rsp_cur_year);
               mismatch_count++;
            end else begin
               due = expected_dates.pop_front();
               if (rsp_cur_day !== due.day) begin
                  $display("%0t: cur_day expected %0d, actual %0d", $time, due.day, rsp_cur_day);
                  mismatch_count++;
               end
               if (rsp_cur_month !== due.month) begin
                  $display("%0t: cur_month expected %0d, actual %0d", $time, due.month,
                           rsp_cur_month);
                  mismatch_count++;
               end
               if (rsp_cur_year !== due.year) begin
                  $display("%0t: cur_year expected %0d, actual %0d", $time, due.year,
                           rsp_cur_year);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy) begin
            taken.op          = req_op;
            taken.day         = req_set_day;
            taken.month       = req_set_month;
            taken.year        = req_set_year;
            taken.count       = req_add_count;
            taken.drain_first = 1'b0;
            expected_dates.push_back(next_calendar_date(taken));
         end
      end
      item_accepted <= !reset && start && !busy;
   end

   // Watchdog: count cycles in which neither an item nor a date moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: nothing moved for %0d cycles, %0d dates outstanding", $time,
                  idle_cycles, expected_dates.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin : run_stimulus
      date_request_type r;
      int               pick;
      int               len;

      // Directed part: empty month on reset, invalid loads, leap and common
      // February, day zero in a valid month, zero counts, year saturation and
      // the field extremes.
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 0);        // zero count on the reset date
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 1);        // empty month steps to Jan 1 next year
      add_request(cdad_pkg::OP_SET, 31, 15, 65535, 0);  // all load fields at their top
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 65535);    // largest count with year stuck at top
      add_request(cdad_pkg::OP_SET, 29, 2, 2024, 0);    // leap February
      add_request(cdad_pkg::OP_SET, 29, 2, 2023, 0);    // day past a common February
      add_request(cdad_pkg::OP_SET, 31, 4, 2000, 0);    // day past a 30-day month
      add_request(cdad_pkg::OP_SET, 0, 5, 1999, 0);     // day zero in a valid month
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 31);       // lands on May 31
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 0);
      add_request(cdad_pkg::OP_SET, 31, 1, 2000, 0);
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 29);       // end of a leap February
      add_request(cdad_pkg::OP_SET, 28, 2, 2001, 0);
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 1);        // common February rolls into March
      add_request(cdad_pkg::OP_SET, 31, 12, 65535, 0);
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 1);        // month wraps, year holds at top
      add_request(cdad_pkg::OP_SET, 15, 12, 65534, 0);
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 400);      // crosses into the top year and on
      add_request(cdad_pkg::OP_SET, 5, 13, 100, 0);     // month beyond December
      add_request(cdad_pkg::OP_SET, 7, 0, 100, 0);      // month zero
      r.drain_first = 1'b1;
      pending_requests.push_back(r);
      add_request(cdad_pkg::OP_SET, 0, 0, 0, 0);
      add_request(cdad_pkg::OP_ADD, 0, 0, 0, 65535);

      // Random part: mostly valid loads followed by runs of advances, with
      // some invalid loads. Unused fields carry random bits throughout.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 199) begin
            r.drain_first = 1'b1;
            pending_requests.push_back(r);
         end
         r.drain_first = 1'b0;
         r.op    = ($urandom_range(0, 9) < 3) ? cdad_pkg::OP_SET : cdad_pkg::OP_ADD;
         r.day   = 5'($urandom);
         r.month = 4'($urandom);
         r.year  = 16'($urandom);
         r.count = 16'($urandom);
         if (r.op == cdad_pkg::OP_SET) begin
            pick = $urandom_range(0, 7);
            if (pick == 0) begin
               r.year = 16'hFFFF - 16'($urandom_range(0, 3));   // near saturation
            end else if (pick == 1) begin
               r.year = {14'($urandom), 2'b00};                  // leap year
            end
            if ($urandom_range(0, 9) != 0) begin
               r.month = 4'($urandom_range(1, 12));
            end
            len = days_in_month(r.month, r.year);
            if ($urandom_range(0, 9) != 0 && len > 0) begin
               r.day = 5'($urandom_range(1, len));
            end
         end else begin
            // keep most walks short; a few long ones and full-range counts
            pick = $urandom_range(0, 99);
            if (pick >= 40) begin
               r.count = 16'($urandom_range(0, 40));
            end else if (pick >= 8) begin
               r.count = 16'($urandom_range(0, 1500));
            end else if (pick >= 2) begin
               r.count = 16'($urandom_range(0, 20000));
            end
         end
         pending_requests.push_back(r);
      end

      // Hold reset, then release it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start || expected_dates.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d date loads and %0d day advances walking %0d months.",
               loads_taken, advances_taken, months_walked);
      $display("Found %0d field mismatches.", mismatch_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
